FILE: sv/ffsa_pkg.sv
// ffsa_pkg: shared constants, types and codes of the first-fit slot allocator
`timescale 1ns / 1ps

package ffsa_pkg;

    localparam int SLOTS       = 16;
    localparam int PAGE_SHIFT  = 12;
    localparam int OFFSET_BITS = 16;

    localparam int REQ_W   = 2;
    localparam int SIZE_W  = 28;
    localparam int ID_W    = 4;
    localparam int STS_W   = 3;
    localparam int PAGE_W  = 20;
    localparam int LEN_W   = 16;
    localparam int REGION_W = 16;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 2;

    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LINK_W  = $clog2(SLOTS + 1);
    localparam int PAGES_W = SIZE_W - PAGE_SHIFT + 1;

    localparam int MAX1_W  = (OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W;
    localparam int MAX2_W  = (MAX1_W > PAGES_W) ? MAX1_W : PAGES_W;
    localparam int MAX3_W  = (MAX2_W > REGION_W) ? MAX2_W : REGION_W;
    localparam int CMP_W   = MAX3_W + 2;

    localparam int IN_W    = 40;
    localparam int OUT_W   = 64;

    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [LINK_W-1:0]      link_t;
    typedef logic [OFFSET_BITS-1:0] off_t;
    typedef logic [LEN_W-1:0]       len_t;
    typedef logic [CMP_W-1:0]       wide_t;
    typedef logic [PAGES_W-1:0]     pages_t;

    localparam link_t NULL_LINK = LINK_W'(SLOTS);
    localparam wide_t MAX_OFF   = CMP_W'((64'd1 << OFFSET_BITS) - 64'd1);
    localparam logic [SIZE_W:0] PAGE_MASK = (SIZE_W + 1)'((64'd1 << PAGE_SHIFT) - 64'd1);

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_QUERY   = 2'd2
    } req_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK       = 3'd0,
        STS_NO_SLOT  = 3'd1,
        STS_NO_SPACE = 3'd2,
        STS_EMPTY    = 3'd3,
        STS_ZERO     = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION    = 2'd0,
        CFG_PHYS_BASE = 2'd1,
        CFG_VIRT_BASE = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_TAIL,
        ST_LINK,
        ST_COMMIT,
        ST_RESP
    } state_t;

    typedef struct packed {
        off_t  off;
        len_t  len;
        link_t nxt;
        link_t prv;
    } slot_entry_t;

    typedef struct packed {
        logic  next_we;
        idx_t  next_addr;
        link_t next_data;
        logic  prev_we;
        idx_t  prev_addr;
        link_t prev_data;
        logic  ent_we;
        idx_t  ent_addr;
        off_t  ent_off;
        len_t  ent_len;
        logic  used_set;
        logic  used_clr;
        idx_t  used_addr;
    } tbl_wr_t;

endpackage

FILE: sv/ffsa_slot_table.sv
// ffsa_slot_table: slot table with offsets, lengths, links and used flags
`timescale 1ns / 1ps

module ffsa_slot_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ffsa_pkg::tbl_wr_t             wr,
    input  ffsa_pkg::idx_t                rd_addr,
    output ffsa_pkg::slot_entry_t         rd,
    output logic [ffsa_pkg::SLOTS-1:0]    used_vec
);

    ffsa_pkg::off_t  off_reg  [ffsa_pkg::SLOTS];
    ffsa_pkg::len_t  len_reg  [ffsa_pkg::SLOTS];
    ffsa_pkg::link_t next_reg [ffsa_pkg::SLOTS];
    ffsa_pkg::link_t prev_reg [ffsa_pkg::SLOTS];
    logic [ffsa_pkg::SLOTS-1:0] used_reg;
    logic [ffsa_pkg::SLOTS-1:0] used_next;

    always_comb begin
        used_next = used_reg;
        if (wr.used_set) begin
            used_next[wr.used_addr] = 1'b1;
        end
        if (wr.used_clr) begin
            used_next[wr.used_addr] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.ent_we) begin
            off_reg[wr.ent_addr] <= wr.ent_off;
            len_reg[wr.ent_addr] <= wr.ent_len;
        end
        if (wr.next_we) begin
            next_reg[wr.next_addr] <= wr.next_data;
        end
        if (wr.prev_we) begin
            prev_reg[wr.prev_addr] <= wr.prev_data;
        end
    end

    assign rd.off   = off_reg[rd_addr];
    assign rd.len   = len_reg[rd_addr];
    assign rd.nxt   = next_reg[rd_addr];
    assign rd.prv   = prev_reg[rd_addr];
    assign used_vec = used_reg;

endmodule

FILE: sv/first_fit_slot_allocator.sv
// first_fit_slot_allocator: first-fit page allocator over a linked slot table
// query, release and an allocate rejected before the walk go from the start state to the response state
// allocate walks the address-ordered slot list one entry a cycle, then links and commits the new slot
// a new request word is taken only in the idle state, after the last result went to the output
// reset: synchronous active-low aresetn clears all used flags, the list head and the config
`timescale 1ns / 1ps

module first_fit_slot_allocator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // req_type[1:0], size_bytes[29:2], slot_id[33:30], zero pad
    input  logic [ffsa_pkg::IN_W-1:0]         s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[2:0], slot_out[6:3], phys_page[26:7], virt_page[46:27], len_pages[62:47], zero pad
    output logic [ffsa_pkg::OUT_W-1:0]        m_tdata,
    input  logic                              cfg_we,
    input  logic [ffsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ffsa_pkg::CFG_W-1:0]        cfg_wdata
);

    ffsa_pkg::state_t state_reg, state_next;

    logic [ffsa_pkg::REGION_W-1:0] region_reg;
    logic [ffsa_pkg::PAGE_W-1:0]   phys_base_reg;
    logic [ffsa_pkg::PAGE_W-1:0]   virt_base_reg;

    logic [ffsa_pkg::REQ_W-1:0] req_reg, req_next;
    ffsa_pkg::pages_t           pages_reg, pages_next;
    logic [ffsa_pkg::ID_W-1:0]  id_reg, id_next;
    ffsa_pkg::idx_t             free_reg, free_next;
    ffsa_pkg::link_t            cur_reg, cur_next;
    ffsa_pkg::link_t            nx_reg, nx_next;
    ffsa_pkg::wide_t            end_reg, end_next;
    ffsa_pkg::link_t            head_reg, head_next;

    logic [ffsa_pkg::STS_W-1:0] res_sts_reg, res_sts_next;
    logic [ffsa_pkg::ID_W-1:0]  res_slot_reg, res_slot_next;
    ffsa_pkg::off_t             res_off_reg, res_off_next;
    ffsa_pkg::len_t             res_len_reg, res_len_next;
    logic                       res_show_reg, res_show_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [ffsa_pkg::STS_W-1:0]  out_sts_reg, out_sts_next;
    logic [ffsa_pkg::ID_W-1:0]   out_slot_reg, out_slot_next;
    logic [ffsa_pkg::PAGE_W-1:0] out_phys_reg, out_phys_next;
    logic [ffsa_pkg::PAGE_W-1:0] out_virt_reg, out_virt_next;
    ffsa_pkg::len_t              out_len_reg, out_len_next;

    ffsa_pkg::tbl_wr_t          tbl_wr;
    ffsa_pkg::idx_t             rd_addr;
    ffsa_pkg::slot_entry_t      rd;
    logic [ffsa_pkg::SLOTS-1:0] used_vec;

    logic [ffsa_pkg::SIZE_W:0]  size_sum;
    logic                       in_accept;
    logic                       out_free;
    ffsa_pkg::idx_t             free_idx;
    logic                       free_found;
    ffsa_pkg::idx_t             id_idx;
    logic                       id_ok;
    logic                       id_used;
    ffsa_pkg::wide_t            limit;
    ffsa_pkg::wide_t            pages_wide;
    ffsa_pkg::wide_t            rd_end;
    ffsa_pkg::wide_t            gap;
    logic                       gap_fits;
    logic                       head_linked;
    logic                       nx_linked;
    logic                       no_room;
    logic                       tail_bad;

    ffsa_slot_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (tbl_wr),
        .rd_addr  (rd_addr),
        .rd       (rd),
        .used_vec (used_vec)
    );

    assign s_tready  = (state_reg == ffsa_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign size_sum = {1'b0, s_tdata[29:2]} + ffsa_pkg::PAGE_MASK;

    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = ffsa_pkg::SLOTS - 1; i >= 0; i--) begin
            if (!used_vec[i]) begin
                free_idx   = ffsa_pkg::idx_t'(i);
                free_found = 1'b1;
            end
        end
    end

    assign id_idx  = ffsa_pkg::idx_t'(id_reg);
    assign id_ok   = (32'(id_reg) < ffsa_pkg::SLOTS);
    assign id_used = id_ok && used_vec[id_idx];

    assign limit = (ffsa_pkg::wide_t'(region_reg) > ffsa_pkg::MAX_OFF)
                 ? ffsa_pkg::MAX_OFF : ffsa_pkg::wide_t'(region_reg);
    assign pages_wide  = ffsa_pkg::wide_t'(pages_reg);
    assign rd_end      = ffsa_pkg::wide_t'(rd.off) + ffsa_pkg::wide_t'(rd.len);
    assign gap         = ffsa_pkg::wide_t'(rd.off) - end_reg;
    assign gap_fits    = $signed(gap) >= $signed(pages_wide);
    assign head_linked = head_reg < ffsa_pkg::NULL_LINK;
    assign nx_linked   = nx_reg < ffsa_pkg::NULL_LINK;
    assign no_room     = pages_wide > limit;
    assign tail_bad    = (end_reg > limit) || ((limit - end_reg) < pages_wide);

    always_comb begin
        if (state_reg == ffsa_pkg::ST_WALK) begin
            rd_addr = ffsa_pkg::idx_t'(nx_reg);
        end else if (req_reg == ffsa_pkg::REQ_ALLOC) begin
            rd_addr = ffsa_pkg::idx_t'(head_reg);
        end else begin
            rd_addr = id_idx;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ffsa_pkg::ST_IDLE: begin
                if (in_accept) begin
                    state_next = ffsa_pkg::ST_START;
                end
            end
            ffsa_pkg::ST_START: begin
                if (req_reg == ffsa_pkg::REQ_ALLOC) begin
                    priority if (pages_reg == '0 || !free_found) begin
                        state_next = ffsa_pkg::ST_RESP;
                    end else if (!head_linked) begin
                        state_next = no_room ? ffsa_pkg::ST_RESP : ffsa_pkg::ST_COMMIT;
                    end else begin
                        state_next = ffsa_pkg::ST_WALK;
                    end
                end else begin
                    state_next = ffsa_pkg::ST_RESP;
                end
            end
            ffsa_pkg::ST_WALK: begin
                priority if (!nx_linked) begin
                    state_next = ffsa_pkg::ST_TAIL;
                end else if (gap_fits) begin
                    state_next = ffsa_pkg::ST_LINK;
                end
            end
            ffsa_pkg::ST_TAIL: begin
                state_next = tail_bad ? ffsa_pkg::ST_RESP : ffsa_pkg::ST_LINK;
            end
            ffsa_pkg::ST_LINK: begin
                state_next = ffsa_pkg::ST_COMMIT;
            end
            ffsa_pkg::ST_COMMIT: begin
                state_next = ffsa_pkg::ST_RESP;
            end
            ffsa_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = ffsa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ffsa_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and table writes
    always_comb begin
        req_next      = req_reg;
        pages_next    = pages_reg;
        id_next       = id_reg;
        free_next     = free_reg;
        cur_next      = cur_reg;
        nx_next       = nx_reg;
        end_next      = end_reg;
        head_next     = head_reg;
        res_sts_next  = res_sts_reg;
        res_slot_next = res_slot_reg;
        res_off_next  = res_off_reg;
        res_len_next  = res_len_reg;
        res_show_next = res_show_reg;
        m_tvalid_next = m_tvalid_reg;
        out_sts_next  = out_sts_reg;
        out_slot_next = out_slot_reg;
        out_phys_next = out_phys_reg;
        out_virt_next = out_virt_reg;
        out_len_next  = out_len_reg;
        tbl_wr        = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ffsa_pkg::ST_IDLE: begin
                if (in_accept) begin
                    req_next   = s_tdata[1:0];
                    pages_next = size_sum[ffsa_pkg::SIZE_W:ffsa_pkg::PAGE_SHIFT];
                    id_next    = s_tdata[33:30];
                end
            end
            ffsa_pkg::ST_START: begin
                res_sts_next  = ffsa_pkg::STS_OK;
                res_slot_next = '0;
                res_off_next  = '0;
                res_len_next  = '0;
                res_show_next = 1'b0;
                free_next     = free_idx;
                cur_next      = head_reg;
                nx_next       = rd.nxt;
                end_next      = rd_end;
                unique case (req_reg)
                    ffsa_pkg::REQ_ALLOC: begin
                        priority if (pages_reg == '0) begin
                            res_sts_next = ffsa_pkg::STS_ZERO;
                        end else if (!free_found) begin
                            res_sts_next = ffsa_pkg::STS_NO_SLOT;
                        end else if (!head_linked) begin
                            cur_next = ffsa_pkg::NULL_LINK;
                            nx_next  = ffsa_pkg::NULL_LINK;
                            end_next = '0;
                            if (no_room) begin
                                res_sts_next = ffsa_pkg::STS_NO_SPACE;
                            end
                        end
                    end
                    ffsa_pkg::REQ_RELEASE: begin
                        res_slot_next = id_reg;
                        if (!id_used) begin
                            res_sts_next = ffsa_pkg::STS_EMPTY;
                        end else begin
                            if (head_reg == ffsa_pkg::link_t'(id_idx)) begin
                                head_next = rd.nxt;
                            end
                            if (rd.nxt < ffsa_pkg::NULL_LINK) begin
                                tbl_wr.prev_we   = 1'b1;
                                tbl_wr.prev_addr = ffsa_pkg::idx_t'(rd.nxt);
                                tbl_wr.prev_data = rd.prv;
                            end
                            if (rd.prv < ffsa_pkg::NULL_LINK) begin
                                tbl_wr.next_we   = 1'b1;
                                tbl_wr.next_addr = ffsa_pkg::idx_t'(rd.prv);
                                tbl_wr.next_data = rd.nxt;
                            end
                            tbl_wr.used_clr  = 1'b1;
                            tbl_wr.used_addr = id_idx;
                        end
                    end
                    ffsa_pkg::REQ_QUERY: begin
                        res_slot_next = id_reg;
                        if (!id_used) begin
                            res_sts_next = ffsa_pkg::STS_EMPTY;
                        end else begin
                            res_off_next  = rd.off;
                            res_len_next  = rd.len;
                            res_show_next = 1'b1;
                        end
                    end
                    default: begin
                        res_sts_next = ffsa_pkg::STS_OK;
                    end
                endcase
            end
            ffsa_pkg::ST_WALK: begin
                if (nx_linked && !gap_fits) begin
                    cur_next = nx_reg;
                    nx_next  = rd.nxt;
                    end_next = rd_end;
                end
            end
            ffsa_pkg::ST_TAIL: begin
                if (tail_bad) begin
                    res_sts_next = ffsa_pkg::STS_NO_SPACE;
                end
            end
            ffsa_pkg::ST_LINK: begin
                tbl_wr.next_we   = 1'b1;
                tbl_wr.next_addr = ffsa_pkg::idx_t'(cur_reg);
                tbl_wr.next_data = ffsa_pkg::link_t'(free_reg);
                if (nx_linked) begin
                    tbl_wr.prev_we   = 1'b1;
                    tbl_wr.prev_addr = ffsa_pkg::idx_t'(nx_reg);
                    tbl_wr.prev_data = ffsa_pkg::link_t'(free_reg);
                end
            end
            ffsa_pkg::ST_COMMIT: begin
                tbl_wr.ent_we    = 1'b1;
                tbl_wr.ent_addr  = free_reg;
                tbl_wr.ent_off   = ffsa_pkg::off_t'(end_reg);
                tbl_wr.ent_len   = ffsa_pkg::len_t'(pages_reg);
                tbl_wr.next_we   = 1'b1;
                tbl_wr.next_addr = free_reg;
                tbl_wr.next_data = nx_reg;
                tbl_wr.prev_we   = 1'b1;
                tbl_wr.prev_addr = free_reg;
                tbl_wr.prev_data = cur_reg;
                tbl_wr.used_set  = 1'b1;
                tbl_wr.used_addr = free_reg;
                if (!(cur_reg < ffsa_pkg::NULL_LINK)) begin
                    head_next = ffsa_pkg::link_t'(free_reg);
                end
                res_sts_next  = ffsa_pkg::STS_OK;
                res_slot_next = ffsa_pkg::ID_W'(free_reg);
                res_off_next  = ffsa_pkg::off_t'(end_reg);
                res_len_next  = ffsa_pkg::len_t'(pages_reg);
                res_show_next = 1'b1;
            end
            ffsa_pkg::ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    out_sts_next  = res_sts_reg;
                    out_slot_next = res_slot_reg;
                    out_len_next  = res_show_reg ? res_len_reg : '0;
                    out_phys_next = res_show_reg
                                  ? phys_base_reg + ffsa_pkg::PAGE_W'(res_off_reg) : '0;
                    out_virt_next = res_show_reg
                                  ? virt_base_reg + ffsa_pkg::PAGE_W'(res_off_reg) : '0;
                end
            end
            default: begin
                m_tvalid_next = m_tvalid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ffsa_pkg::ST_IDLE;
            head_reg      <= ffsa_pkg::NULL_LINK;
            m_tvalid_reg  <= 1'b0;
            region_reg    <= '0;
            phys_base_reg <= '0;
            virt_base_reg <= '0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_index)
                    ffsa_pkg::CFG_REGION:    region_reg    <= cfg_wdata[ffsa_pkg::REGION_W-1:0];
                    ffsa_pkg::CFG_PHYS_BASE: phys_base_reg <= cfg_wdata;
                    ffsa_pkg::CFG_VIRT_BASE: virt_base_reg <= cfg_wdata;
                    default: begin
                        region_reg <= region_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        pages_reg    <= pages_next;
        id_reg       <= id_next;
        free_reg     <= free_next;
        cur_reg      <= cur_next;
        nx_reg       <= nx_next;
        end_reg      <= end_next;
        res_sts_reg  <= res_sts_next;
        res_slot_reg <= res_slot_next;
        res_off_reg  <= res_off_next;
        res_len_reg  <= res_len_next;
        res_show_reg <= res_show_next;
        out_sts_reg  <= out_sts_next;
        out_slot_reg <= out_slot_next;
        out_phys_reg <= out_phys_next;
        out_virt_reg <= out_virt_next;
        out_len_reg  <= out_len_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_len_reg, out_virt_reg, out_phys_reg, out_slot_reg, out_sts_reg};

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ffsa_pkg::ST_START)
        else $error("accepted word did not start the sequencer");

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ffsa_pkg::ST_RESP))
        else $error("result word raised outside the response step");

    a_head_used: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg < ffsa_pkg::NULL_LINK |-> used_vec[ffsa_pkg::idx_t'(head_reg)])
        else $error("list head points to a free slot");

    a_walk_cursor_used: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ffsa_pkg::ST_WALK |-> used_vec[ffsa_pkg::idx_t'(cur_reg)])
        else $error("list walk reached a free slot");
`endif

endmodule

FILE: dv/tb_top.sv
// tb_top: self-checking testbench for the first-fit slot allocator with an in-bench slot table model
`timescale 1ns / 1ps

module tb_top;
    import ffsa_pkg::*;

    localparam int                 CLK_PERIOD   = 12;
    localparam int                 STALL_LIMIT  = 4000;
    localparam int                 MAX_PAGE_OFF = (1 << OFFSET_BITS) - 1;
    localparam int                 NIL_SLOT     = SLOTS;
    localparam logic [REQ_W-1:0]   REQ_UNDEFINED = 2'd3;

    typedef struct {
        status_t             status;
        logic [ID_W-1:0]     slot;
        logic [PAGE_W-1:0]   phys;
        logic [PAGE_W-1:0]   virt;
        logic [LEN_W-1:0]    len;
    } resp_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    // req_type[1:0], size_bytes[29:2], slot_id[33:30], zero pad
    logic [IN_W-1:0]   s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    // status[2:0], slot_out[6:3], phys_page[26:7], virt_page[46:27], len_pages[62:47], zero pad
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_REGION;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    // slot table model
    bit     used_tab [SLOTS];
    int     off_tab  [SLOTS];
    int     len_tab  [SLOTS];
    int     nxt_tab  [SLOTS];
    int     prv_tab  [SLOTS];
    int     head_slot = NIL_SLOT;
    int     map_region = 0;
    int     map_phys   = 0;
    int     map_virt   = 0;

    resp_t  pending_resp[$];
    int     mismatch_count = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_request   = 0;
    int     hold_left      = 0;
    int     quiet_cycles   = 0;

    first_fit_slot_allocator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            used_tab[i] = 1'b0;
            off_tab[i]  = 0;
            len_tab[i]  = 0;
            nxt_tab[i]  = NIL_SLOT;
            prv_tab[i]  = NIL_SLOT;
        end
    end

    function automatic resp_t predict_response(logic [REQ_W-1:0] req, logic [SIZE_W-1:0] size,
                                               logic [ID_W-1:0] id);
        resp_t   r;
        longint  pages;
        longint  lim;
        longint  off;
        longint  gap;
        int      f;
        int      cur;
        int      nx;
        int      pv;
        bit      placed;
        r.status = STS_OK;
        r.slot   = '0;
        r.phys   = '0;
        r.virt   = '0;
        r.len    = '0;
        if (req == REQ_ALLOC) begin
            pages = (longint'(size) + (longint'(1) << PAGE_SHIFT) - 1) >> PAGE_SHIFT;
            f = 0;
            while (f < SLOTS && used_tab[f]) f++;
            if (pages == 0) begin
                r.status = STS_ZERO;
            end else if (f == SLOTS) begin
                r.status = STS_NO_SLOT;
            end else begin
                lim = (map_region > MAX_PAGE_OFF) ? MAX_PAGE_OFF : map_region;
                placed = 1'b1;
                off = 0;
                if (head_slot == NIL_SLOT) begin
                    if (pages > lim) begin
                        placed = 1'b0;
                    end else begin
                        nxt_tab[f] = NIL_SLOT;
                        prv_tab[f] = NIL_SLOT;
                        head_slot = f;
                    end
                end else begin
                    cur = head_slot;
                    for (int steps = 0; steps < SLOTS; steps++) begin
                        nx = nxt_tab[cur];
                        if (nx == NIL_SLOT) break;
                        gap = longint'(off_tab[nx]) - off_tab[cur] - len_tab[cur];
                        if (gap >= pages) break;
                        cur = nx;
                    end
                    nx = nxt_tab[cur];
                    off = longint'(off_tab[cur]) + len_tab[cur];
                    if (nx != NIL_SLOT) begin
                        nxt_tab[f] = nx;
                        prv_tab[f] = cur;
                        prv_tab[nx] = f;
                        nxt_tab[cur] = f;
                    end else if (off > lim || lim - off < pages) begin
                        placed = 1'b0;
                    end else begin
                        nxt_tab[f] = NIL_SLOT;
                        prv_tab[f] = cur;
                        nxt_tab[cur] = f;
                    end
                end
                if (!placed) begin
                    r.status = STS_NO_SPACE;
                end else begin
                    used_tab[f] = 1'b1;
                    off_tab[f]  = int'(off & MAX_PAGE_OFF);
                    len_tab[f]  = int'(pages & 16'hFFFF);
                    r.slot = ID_W'(f);
                    r.phys = PAGE_W'(map_phys + off_tab[f]);
                    r.virt = PAGE_W'(map_virt + off_tab[f]);
                    r.len  = LEN_W'(len_tab[f]);
                end
            end
        end else if (req == REQ_RELEASE || req == REQ_QUERY) begin
            r.slot = id;
            if (!used_tab[id]) begin
                r.status = STS_EMPTY;
            end else if (req == REQ_QUERY) begin
                r.phys = PAGE_W'(map_phys + off_tab[id]);
                r.virt = PAGE_W'(map_virt + off_tab[id]);
                r.len  = LEN_W'(len_tab[id]);
            end else begin
                nx = nxt_tab[id];
                pv = prv_tab[id];
                if (head_slot == id) head_slot = nx;
                if (nx != NIL_SLOT) prv_tab[nx] = pv;
                if (pv != NIL_SLOT) nxt_tab[pv] = nx;
                nxt_tab[id]  = NIL_SLOT;
                prv_tab[id]  = NIL_SLOT;
                used_tab[id] = 1'b0;
                off_tab[id]  = 0;
                len_tab[id]  = 0;
            end
        end
        return r;
    endfunction

    task automatic send_request(logic [REQ_W-1:0] req, logic [SIZE_W-1:0] size,
                                logic [ID_W-1:0] id);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - REQ_W - SIZE_W - ID_W){1'b0}}, id, size, req};
        do @(posedge aclk); while (!s_tready);
        pending_resp.push_back(predict_response(req, size, id));
    endtask

    task automatic send_random_request();
        int                 pick;
        int                 sel;
        int                 live[$];
        logic [REQ_W-1:0]   req;
        logic [SIZE_W-1:0]  sz;
        logic [ID_W-1:0]    id;
        pick = $urandom_range(99);
        sz = SIZE_W'($urandom());
        id = ID_W'($urandom());
        for (int n = 0; n < SLOTS; n++) if (used_tab[n]) live.push_back(n);
        if (pick < 4) begin
            req = REQ_UNDEFINED;
        end else if (pick < 52) begin
            req = REQ_ALLOC;
            sel = $urandom_range(19);
            if (sel == 0) sz = '0;
            else if (sel == 1) sz = SIZE_W'($urandom());
            else if (sel == 2) sz = SIZE_W'($urandom_range(1, 16)) << PAGE_SHIFT;
            else if (sel == 3) sz = SIZE_W'($urandom_range(1, 1 << 22));
            else sz = SIZE_W'(($urandom_range(0, 5) << PAGE_SHIFT) + $urandom_range(1, 4095));
        end else begin
            req = (pick < 80) ? REQ_RELEASE : REQ_QUERY;
            if (live.size() != 0 && $urandom_range(99) < 85)
                id = ID_W'(live[$urandom_range(live.size() - 1)]);
        end
        send_request(req, sz, id);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_resp.size() != 0);
    endtask

    task automatic set_region_map(int region, int phys, int virt);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_REGION;
        cfg_wdata <= CFG_W'(region);
        @(posedge aclk);
        cfg_index <= CFG_PHYS_BASE;
        cfg_wdata <= CFG_W'(phys);
        @(posedge aclk);
        cfg_index <= CFG_VIRT_BASE;
        cfg_wdata <= CFG_W'(virt);
        @(posedge aclk);
        cfg_we <= 1'b0;
        map_region = region & 16'hFFFF;
        map_phys   = phys & 20'hFFFFF;
        map_virt   = virt & 20'hFFFFF;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // zero size, rounding, oversize, release and query of a free slot, gap reuse, head gap
    task automatic test_directed();
        set_idling(0, 0);
        set_region_map(64, 20'hFFFF0, 20'h12345);
        send_request(REQ_ALLOC, 28'd0, 4'd0);
        send_request(REQ_ALLOC, 28'd1, 4'hF);
        send_request(REQ_ALLOC, 28'd4096, 4'd0);
        send_request(REQ_ALLOC, 28'd4097, 4'd0);
        send_request(REQ_ALLOC, 28'hFFFFFFF, 4'hF);
        send_request(REQ_QUERY, 28'd0, 4'd1);
        send_request(REQ_RELEASE, 28'd0, 4'd1);
        send_request(REQ_RELEASE, 28'hFFFFFFF, 4'd1);
        send_request(REQ_QUERY, 28'd0, 4'd1);
        send_request(REQ_ALLOC, 28'd4096, 4'd0);
        send_request(REQ_RELEASE, 28'd0, 4'd0);
        send_request(REQ_ALLOC, 28'd4095, 4'd0);
        send_request(REQ_UNDEFINED, 28'hAAAAAAA, 4'h5);
        wait_drain();
    endtask

    // full table, zero size on a full table, region shrunk below the blocks in use
    task automatic test_table_full();
        set_idling(0, 0);
        for (int i = 0; i < SLOTS - 3; i++)
            send_request(REQ_ALLOC, SIZE_W'($urandom_range(1, 4096)), ID_W'($urandom()));
        send_request(REQ_ALLOC, 28'd4096, 4'd0);
        send_request(REQ_ALLOC, 28'd0, 4'd0);
        wait_drain();
        set_region_map(1, 0, 20'hFFFFF);
        send_request(REQ_RELEASE, 28'd0, 4'd15);
        send_request(REQ_ALLOC, 28'd4096, 4'd0);
        wait_drain();
    endtask

    // long output hold-off fills the block, then a sender pause until all results are back
    task automatic test_backpressure();
        set_idling(0, 0);
        set_region_map(65535, $urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF));
        hold_request = 400;
        for (int i = 0; i < 40; i++) send_random_request();
        wait_drain();
        for (int i = 0; i < 20; i++) send_random_request();
        wait_drain();
    endtask

    task automatic test_random();
        int region;
        int phys;
        int virt;
        for (int p = 0; p < 8; p++) begin
            phys = $urandom_range(0, 20'hFFFFF);
            virt = $urandom_range(0, 20'hFFFFF);
            case (p)
                0: begin region = 65535; phys = 0; virt = 0; end
                1: begin region = 24; phys = 20'hFFFFF; virt = 20'hFFFFF; end
                2: region = 0;
                3: region = 40;
                4: region = $urandom_range(1, 200);
                5: begin region = 65535; phys = 20'hFFFF0; virt = 20'h00010; end
                6: region = 8;
                default: region = $urandom_range(0, 65535);
            endcase
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(69, 0);
                2: set_idling(0, 69);
                default: set_idling(28, 28);
            endcase
            set_region_map(region, phys, virt);
            for (int i = 0; i < 205; i++) send_random_request();
            wait_drain();
        end
    endtask

    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        resp_t got;
        resp_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = status_t'(m_tdata[2:0]);
            got.slot   = m_tdata[6:3];
            got.phys   = m_tdata[26:7];
            got.virt   = m_tdata[46:27];
            got.len    = m_tdata[62:47];
            if (pending_resp.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: status=%0d slot=%0d phys=%h virt=%h len=%0d",
                             got.status, got.slot, got.phys, got.virt, got.len);
            end else begin
                want = pending_resp.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.phys !== want.phys || got.virt !== want.virt || got.len !== want.len) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected status=%0d slot=%0d phys=%h virt=%h len=%0d",
                                 want.status, want.slot, want.phys, want.virt, want.len);
                        $display("          got      status=%0d slot=%0d phys=%h virt=%h len=%0d",
                                 got.status, got.slot, got.phys, got.virt, got.len);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT) @(posedge aclk);
        $display("FAIL first_fit_slot_allocator");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_table_full();
        test_backpressure();
        test_random();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && pending_resp.size() == 0) begin
            $display("PASS first_fit_slot_allocator");
        end else begin
            $display("FAIL first_fit_slot_allocator");
        end
        $finish;
    end

endmodule
